@@ src/tccw_pkg.sv @@
package tccw_pkg;

  // Screen geometry limits
  localparam int MAX_COLUMNS = 80;
  localparam int MAX_ROWS    = 25;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;

  // Widths
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int IDX_W    = 11;
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int COL_W    = $clog2(MAX_COLUMNS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int NC_W     = $clog2(MAX_COLUMNS + 1);
  localparam int NR_W     = $clog2(MAX_ROWS + 1);
  localparam int PROD_W   = ROW_W + NC_W;
  localparam int CFG_COLS_W = 7;
  localparam int CFG_ROWS_W = 5;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd2;

  localparam logic [CFG_COLS_W-1:0] COLUMNS_RST = 7'd80;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RST    = 5'd25;
  localparam logic [COLOR_W-1:0]    COLOR_RST   = 8'd7;

  // Actions and special characters
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

  localparam logic [CELL_W-1:0] RESET_CELL = {COLOR_RST, CHAR_SPACE};

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_position;
    logic [CELL_W-1:0] read_value;
    logic              scrolled;
  } out_item_t;

  typedef struct packed {
    logic [NC_W-1:0]    nc;
    logic [NR_W-1:0]    nr;
    logic [COLOR_W-1:0] color;
  } geom_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FLUSH,
    S_OUT
  } state_e;

endpackage

@@ src/tccw_cell_ram.sv @@
module tccw_cell_ram (
  input  logic                      clk_i,
  input  tccw_pkg::mem_wr_t         wr_i,
  input  tccw_pkg::mem_rd_t         rd_i,
  output logic [tccw_pkg::CELL_W-1:0] rdata_o
);

  logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::STORE_DEPTH];
  logic [tccw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tccw_ctrl.sv @@
module tccw_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tccw_pkg::geom_t             geom_i,
  input  logic                        in_valid_i,
  input  tccw_pkg::in_item_t          in_item_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  output tccw_pkg::out_item_t         out_item_o,
  input  logic                        out_stall_i,
  output tccw_pkg::mem_wr_t           mem_wr_o,
  output tccw_pkg::mem_rd_t           mem_rd_o,
  input  logic [tccw_pkg::CELL_W-1:0] mem_rdata_i
);

  tccw_pkg::state_e state_q, state_d;

  logic [tccw_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tccw_pkg::COL_W-1:0]  col_q, col_d;
  logic                        act_q, act_d;
  logic [tccw_pkg::CHAR_W-1:0] ch_q, ch_d;
  logic                        oob_q, oob_d;
  logic [tccw_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  logic [tccw_pkg::ADDR_W-1:0] copy_len_q, copy_len_d;
  logic                        pend_q, pend_d;
  logic [tccw_pkg::ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic                        pend_fill_q, pend_fill_d;
  tccw_pkg::out_item_t         res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  tccw_pkg::out_item_t         out_q, out_d;

  logic accept, out_free;

  // Start-of-item cursor clamp
  logic [tccw_pkg::COL_W-1:0] col_cl;
  logic [tccw_pkg::ROW_W-1:0] row_cl;

  // Execute-cycle datapath
  logic                         is_nl, is_bs, is_put, advance;
  logic [tccw_pkg::COL_W-1:0]   col_w, col_start, col_n;
  logic [tccw_pkg::ROW_W-1:0]   row_n;
  logic [tccw_pkg::NC_W-1:0]    col_inc;
  logic [tccw_pkg::NR_W-1:0]    row_inc;
  logic                         wrap, scroll;
  logic [tccw_pkg::PROD_W-1:0]  base_prod, pos_prod;
  logic [tccw_pkg::ADDR_W-1:0]  put_addr;
  tccw_pkg::out_item_t          exec_res;

  // Scroll pass
  logic                         copy_cell, scroll_last;
  logic [tccw_pkg::CELL_W-1:0]  blank_cell;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign col_cl = (tccw_pkg::NC_W'(col_q) >= geom_i.nc) ?
                  tccw_pkg::COL_W'(geom_i.nc - 1'b1) : col_q;
  assign row_cl = (tccw_pkg::NR_W'(row_q) >= geom_i.nr) ?
                  tccw_pkg::ROW_W'(geom_i.nr - 1'b1) : row_q;

  assign is_put = (act_q == tccw_pkg::ACT_PUT);
  assign is_nl  = is_put && (ch_q == tccw_pkg::CHAR_NEWLINE);
  assign is_bs  = is_put && (ch_q == tccw_pkg::CHAR_BACKSPACE);
  assign advance = is_put && !is_bs;

  assign col_w     = (is_bs && col_q != '0) ? col_q - 1'b1 : col_q;
  assign col_start = is_nl ? tccw_pkg::COL_W'(geom_i.nc - 1'b1) : col_q;
  assign col_inc   = tccw_pkg::NC_W'(col_start) + 1'b1;
  assign wrap      = advance && (col_inc == geom_i.nc);
  assign row_inc   = tccw_pkg::NR_W'(row_q) + 1'b1;
  assign scroll    = wrap && (row_inc == geom_i.nr);

  always_comb begin
    if (wrap) begin
      col_n = '0;
      row_n = scroll ? row_q : tccw_pkg::ROW_W'(row_inc);
    end else if (advance) begin
      col_n = tccw_pkg::COL_W'(col_inc);
      row_n = row_q;
    end else begin
      col_n = col_w;
      row_n = row_q;
    end
  end

  assign base_prod = tccw_pkg::PROD_W'(row_q) * tccw_pkg::PROD_W'(geom_i.nc);
  assign pos_prod  = tccw_pkg::PROD_W'(row_n) * tccw_pkg::PROD_W'(geom_i.nc);
  assign put_addr  = tccw_pkg::ADDR_W'(base_prod) + tccw_pkg::ADDR_W'(col_w);

  always_comb begin
    exec_res.cursor_position = tccw_pkg::IDX_W'(pos_prod) + tccw_pkg::IDX_W'(col_n);
    exec_res.read_value      = (!is_put && !oob_q) ? mem_rdata_i : '0;
    exec_res.scrolled        = scroll;
  end

  assign blank_cell  = {geom_i.color, tccw_pkg::CHAR_SPACE};
  assign copy_cell   = cnt_q < copy_len_q;
  assign scroll_last = cnt_q == (copy_len_q + tccw_pkg::ADDR_W'(geom_i.nc) - 1'b1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccw_pkg::S_CLEAR: begin
        if (int'(cnt_q) == tccw_pkg::STORE_DEPTH - 1) state_d = tccw_pkg::S_IDLE;
      end
      tccw_pkg::S_IDLE: begin
        if (accept) state_d = tccw_pkg::S_EXEC;
      end
      tccw_pkg::S_EXEC: begin
        if (scroll)        state_d = tccw_pkg::S_SCROLL;
        else if (out_free) state_d = tccw_pkg::S_IDLE;
        else               state_d = tccw_pkg::S_OUT;
      end
      tccw_pkg::S_SCROLL: begin
        if (scroll_last) state_d = tccw_pkg::S_FLUSH;
      end
      tccw_pkg::S_FLUSH: begin
        state_d = out_free ? tccw_pkg::S_IDLE : tccw_pkg::S_OUT;
      end
      tccw_pkg::S_OUT: begin
        if (out_free) state_d = tccw_pkg::S_IDLE;
      end
      default: state_d = tccw_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    act_d       = act_q;
    ch_d        = ch_q;
    oob_d       = oob_q;
    cnt_d       = cnt_q;
    copy_len_d  = copy_len_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_fill_d = pend_fill_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_wr_o    = '0;
    mem_rd_o    = '0;

    unique case (state_q)
      tccw_pkg::S_CLEAR: begin
        mem_wr_o.en   = 1'b1;
        mem_wr_o.addr = cnt_q;
        mem_wr_o.data = tccw_pkg::RESET_CELL;
        cnt_d         = cnt_q + 1'b1;
      end
      tccw_pkg::S_IDLE: begin
        if (accept) begin
          act_d = in_item_i.action;
          ch_d  = in_item_i.char_code;
          oob_d = int'(in_item_i.read_index) >= tccw_pkg::STORE_DEPTH;
          col_d = col_cl;
          row_d = row_cl;
          mem_rd_o.en   = (in_item_i.action == tccw_pkg::ACT_READ) &&
                          (int'(in_item_i.read_index) < tccw_pkg::STORE_DEPTH);
          mem_rd_o.addr = tccw_pkg::ADDR_W'(in_item_i.read_index);
        end
      end
      tccw_pkg::S_EXEC: begin
        mem_wr_o.en   = is_put && !is_nl;
        mem_wr_o.addr = put_addr;
        mem_wr_o.data = {geom_i.color, is_bs ? tccw_pkg::CHAR_SPACE : ch_q};
        col_d = col_n;
        row_d = row_n;
        res_d = exec_res;
        if (scroll) begin
          // cursor sits at column 0 of the last row: its index is the copy length
          copy_len_d = tccw_pkg::ADDR_W'(exec_res.cursor_position);
          cnt_d      = '0;
          pend_d     = 1'b0;
        end else if (out_free) begin
          out_d       = exec_res;
          out_valid_d = 1'b1;
        end
      end
      tccw_pkg::S_SCROLL: begin
        // read cell i+columns and write it to i in the next cycle; past the copy length write blanks
        mem_rd_o.en   = copy_cell;
        mem_rd_o.addr = cnt_q + tccw_pkg::ADDR_W'(geom_i.nc);
        mem_wr_o.en   = pend_q;
        mem_wr_o.addr = pend_addr_q;
        mem_wr_o.data = pend_fill_q ? blank_cell : mem_rdata_i;
        pend_d      = 1'b1;
        pend_addr_d = cnt_q;
        pend_fill_d = !copy_cell;
        cnt_d       = cnt_q + 1'b1;
      end
      tccw_pkg::S_FLUSH: begin
        mem_wr_o.en   = pend_q;
        mem_wr_o.addr = pend_addr_q;
        mem_wr_o.data = pend_fill_q ? blank_cell : mem_rdata_i;
        pend_d        = 1'b0;
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      tccw_pkg::S_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::S_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    ch_q        <= ch_d;
    oob_q       <= oob_d;
    copy_len_q  <= copy_len_d;
    pend_addr_q <= pend_addr_d;
    pend_fill_q <= pend_fill_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != tccw_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == tccw_pkg::S_EXEC)
    else $error("accepted item not executed next cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < tccw_pkg::MAX_ROWS && int'(col_q) < tccw_pkg::MAX_COLUMNS)
    else $error("cursor outside the store");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_o.en |-> int'(mem_wr_o.addr) < tccw_pkg::STORE_DEPTH)
    else $error("cell write beyond the store");

  a_rw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_o.en && mem_rd_o.en |-> mem_wr_o.addr != mem_rd_o.addr)
    else $error("read and write of the same cell in one cycle");

endmodule

@@ src/text_console_cell_writer_top.sv @@
// Text-mode console cell writer. A put transfer (action 0) writes the character at the cursor
// in the current text color and advances; newline wraps to the next row, backspace steps back
// a column unless at column 0 and blanks that cell. A read transfer (action 1) returns one
// cell word. Every item gives one result carrying the cursor index after the item. An item
// is accepted, then executed in one step on the cell RAM (one port per direction). A put
// that runs past the last row scrolls: the screen is copied up through the cell RAM one cell
// per cycle and the last row is blanked. After reset a clearing pass fills all 2000 RAM cells
// with blank cells; input is stalled until it ends, while register writes are taken at any
// time. The next item can be accepted while the result waits in the output register.
module text_console_cell_writer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  tccw_pkg::in_item_t              in_item_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output tccw_pkg::out_item_t             out_item_o,
  input  logic                            out_stall_i
);

  logic [tccw_pkg::CFG_COLS_W-1:0] columns_q;
  logic [tccw_pkg::CFG_ROWS_W-1:0] rows_q;
  logic [tccw_pkg::COLOR_W-1:0]    color_q;

  tccw_pkg::geom_t             geom;
  tccw_pkg::mem_wr_t           mem_wr;
  tccw_pkg::mem_rd_t           mem_rd;
  logic [tccw_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= tccw_pkg::COLUMNS_RST;
      rows_q    <= tccw_pkg::ROWS_RST;
      color_q   <= tccw_pkg::COLOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tccw_pkg::CFG_COLUMNS:    columns_q <= cfg_wdata_i[tccw_pkg::CFG_COLS_W-1:0];
        tccw_pkg::CFG_ROWS:       rows_q    <= cfg_wdata_i[tccw_pkg::CFG_ROWS_W-1:0];
        tccw_pkg::CFG_TEXT_COLOR: color_q   <= cfg_wdata_i[tccw_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry held to 2..MAX
  always_comb begin
    if (int'(columns_q) < 2)                           geom.nc = tccw_pkg::NC_W'(2);
    else if (int'(columns_q) > tccw_pkg::MAX_COLUMNS)  geom.nc = tccw_pkg::NC_W'(tccw_pkg::MAX_COLUMNS);
    else                                               geom.nc = tccw_pkg::NC_W'(columns_q);
    if (int'(rows_q) < 2)                              geom.nr = tccw_pkg::NR_W'(2);
    else if (int'(rows_q) > tccw_pkg::MAX_ROWS)        geom.nr = tccw_pkg::NR_W'(tccw_pkg::MAX_ROWS);
    else                                               geom.nr = tccw_pkg::NR_W'(rows_q);
    geom.color = color_q;
  end

  tccw_cell_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i),
    .mem_wr_o    (mem_wr),
    .mem_rd_o    (mem_rd),
    .mem_rdata_i (mem_rdata)
  );

endmodule

@@ test/text_console_cell_writer_checker.sv @@
`timescale 1ns / 1ps

module text_console_cell_writer_checker
  import tccw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  in_item_t              in_item_i,
  input  logic                  in_stall_i,
  input  logic                  out_valid_i,
  input  out_item_t             out_item_i,
  input  logic                  out_stall_i,
  output int unsigned           mismatches_o,
  output int unsigned           outstanding_o,
  output int unsigned           results_o,
  output int unsigned           scrolls_o
);

  logic [CELL_W-1:0]     screen [STORE_DEPTH];
  int unsigned           cur_row;
  int unsigned           cur_col;
  logic [CFG_COLS_W-1:0] columns_q;
  logic [CFG_ROWS_W-1:0] rows_q;
  logic [COLOR_W-1:0]    color_q;
  out_item_t             owed_reports [$];

  // Updates the screen copy and cursor for one accepted transfer.
  function automatic out_item_t apply_to_screen(in_item_t it);
    int unsigned nc;
    int unsigned nr;
    logic        moves_on;
    out_item_t   res;
    nc = (columns_q < 2) ? 2 : ((int'(columns_q) > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_q));
    nr = (rows_q < 2) ? 2 : ((int'(rows_q) > MAX_ROWS) ? MAX_ROWS : int'(rows_q));
    res = '0;
    moves_on = 1'b1;
    // geometry may have shrunk under the cursor
    if (cur_col >= nc) cur_col = nc - 1;
    if (cur_row >= nr) cur_row = nr - 1;
    if (it.action == ACT_READ) begin
      if (int'(it.read_index) < STORE_DEPTH) res.read_value = screen[it.read_index];
      moves_on = 1'b0;
    end else if (it.char_code == CHAR_NEWLINE) begin
      cur_col = nc - 1;
    end else if (it.char_code == CHAR_BACKSPACE) begin
      if (cur_col != 0) cur_col = cur_col - 1;
      screen[cur_row * nc + cur_col] = {color_q, CHAR_SPACE};
      moves_on = 1'b0;
    end else begin
      screen[cur_row * nc + cur_col] = {color_q, it.char_code};
    end
    if (moves_on) begin
      cur_col = cur_col + 1;
      if (cur_col == nc) begin
        cur_col = 0;
        cur_row = cur_row + 1;
        if (cur_row == nr) begin
          cur_row = nr - 1;
          for (int y = 0; y + 1 < nr; y++) begin
            for (int x = 0; x < nc; x++) screen[y * nc + x] = screen[(y + 1) * nc + x];
          end
          for (int x = 0; x < nc; x++) screen[(nr - 1) * nc + x] = {color_q, CHAR_SPACE};
          res.scrolled = 1'b1;
          scrolls_o++;
        end
      end
    end
    res.cursor_position = IDX_W'(cur_row * nc + cur_col);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) screen[i] = RESET_CELL;
      cur_row = 0;
      cur_col = 0;
      columns_q = COLUMNS_RST;
      rows_q = ROWS_RST;
      color_q = COLOR_RST;
      owed_reports.delete();
      mismatches_o = 0;
      results_o = 0;
      scrolls_o = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMNS:    columns_q = cfg_wdata_i[CFG_COLS_W-1:0];
          CFG_ROWS:       rows_q = cfg_wdata_i[CFG_ROWS_W-1:0];
          CFG_TEXT_COLOR: color_q = cfg_wdata_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      // results first: a result can never belong to a transfer taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (owed_reports.size() == 0) begin
          if (mismatches_o < 10)
            $display("[%0t] unexpected result: cursor %0d read %h scrolled %0b", $time,
                     out_item_i.cursor_position, out_item_i.read_value, out_item_i.scrolled);
          mismatches_o++;
        end else begin
          want = owed_reports.pop_front();
          results_o++;
          if (out_item_i.cursor_position !== want.cursor_position ||
              out_item_i.read_value !== want.read_value ||
              out_item_i.scrolled !== want.scrolled) begin
            if (mismatches_o < 10)
              $display("[%0t] mismatch: cursor exp %0d got %0d, read exp %h got %h, scrolled exp %0b got %0b",
                       $time, want.cursor_position, out_item_i.cursor_position,
                       want.read_value, out_item_i.read_value, want.scrolled, out_item_i.scrolled);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) owed_reports.push_back(apply_to_screen(in_item_i));
      outstanding_o <= owed_reports.size();
    end
  end

endmodule

@@ test/text_console_cell_writer_top_tb.sv @@
`timescale 1ns / 1ps

module text_console_cell_writer_top_tb;
  import tccw_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD,
    STALL_LONG
  } stall_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  in_item_t              in_item_i;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_item_t             out_item_o;
  logic                  out_stall_i;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results;
  int unsigned scrolls;
  int unsigned items_sent;
  int unsigned settings_used;
  int unsigned live_cells;
  int unsigned burst_left;
  int unsigned quiet_cycles;

  text_console_cell_writer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  text_console_cell_writer_checker screen_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_item_i     (in_item_i),
    .in_stall_i    (in_stall_o),
    .out_valid_i   (out_valid_o),
    .out_item_i    (out_item_o),
    .out_stall_i   (out_stall_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .results_o     (results),
    .scrolls_o     (scrolls)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stall pattern, switching at random among the five stall modes.
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned tick;
    mode = STALL_NONE;
    mode_left = 0;
    tick = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 4));
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      tick++;
      case (mode)
        STALL_NONE:        out_stall_i <= 1'b0;
        STALL_LIGHT:       out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:       out_stall_i <= ($urandom_range(0, 3) != 0);
        STALL_EVERY_THIRD: out_stall_i <= (tick % 3 == 0);
        default:           out_stall_i <= (tick % 40 < 24);
      endcase
    end
  end

  // Watchdog: too long without any transfer or register write ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still owed",
               quiet_cycles, outstanding);
      $display("text_console_cell_writer_top verification failed");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic act, logic [CHAR_W-1:0] ch,
                                       logic [IDX_W-1:0] idx);
    in_item_t it;
    it.action = act;
    it.char_code = ch;
    it.read_index = idx;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.read_index = IDX_W'($urandom_range(0, 2047));
    it.char_code = CHAR_W'($urandom_range(0, 255));
    if (pick < 20) begin
      it.action = ACT_READ;
      if (pick < 16) it.read_index = IDX_W'($urandom_range(0, live_cells - 1));
    end else begin
      it.action = ACT_PUT;
      if (pick < 34) it.char_code = CHAR_NEWLINE;
      else if (pick < 44) it.char_code = CHAR_BACKSPACE;
      else if (pick < 70) it.char_code = CHAR_W'($urandom_range(32, 126));
    end
    return it;
  endfunction

  // Holds the item until the block takes it; returns at the transfer edge.
  task automatic push_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
  endtask

  task automatic settle();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_screen(int unsigned cols, int unsigned rws, int unsigned color);
    int unsigned nc;
    int unsigned nr;
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_COLUMNS;
    cfg_wdata_i <= CFG_DATA_W'(cols);
    @(posedge clk_i);
    cfg_index_i <= CFG_ROWS;
    cfg_wdata_i <= CFG_DATA_W'(rws);
    @(posedge clk_i);
    cfg_index_i <= CFG_TEXT_COLOR;
    cfg_wdata_i <= CFG_DATA_W'(color);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nc = (cols < 2) ? 2 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
    nr = (rws < 2) ? 2 : ((rws > MAX_ROWS) ? MAX_ROWS : rws);
    live_cells = nc * nr;
    settings_used++;
  endtask

  initial begin
    int unsigned cols;
    int unsigned rws;
    int unsigned color;
    int unsigned count;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_COLUMNS;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    burst_left = 0;
    items_sent = 0;
    settings_used = 1;
    live_cells = STORE_DEPTH;
    quiet_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: blank cells, out-of-range reads, edge characters
    push_item(mk_item(ACT_READ, 8'h00, 11'd0));
    push_item(mk_item(ACT_READ, 8'hFF, 11'd1999));
    push_item(mk_item(ACT_READ, 8'h00, 11'd2000));
    push_item(mk_item(ACT_READ, 8'hA5, 11'd2047));
    push_item(mk_item(ACT_PUT, CHAR_BACKSPACE, 11'd0));   // backspace at column zero
    push_item(mk_item(ACT_PUT, 8'h00, 11'h7FF));
    push_item(mk_item(ACT_PUT, 8'hFF, 11'h555));
    push_item(mk_item(ACT_PUT, 8'h41, 11'h2AA));
    push_item(mk_item(ACT_PUT, CHAR_BACKSPACE, 11'd0));
    push_item(mk_item(ACT_PUT, CHAR_NEWLINE, 11'd0));
    push_item(mk_item(ACT_PUT, 8'hAA, 11'd0));
    push_item(mk_item(ACT_READ, 8'h00, 11'd1));
    push_item(mk_item(ACT_READ, 8'h00, 11'd80));
    in_valid_i <= 1'b0;
    settle();

    // tiny screen: wrap, newline on the last row and scrolling
    set_screen(3, 2, 8'hC3);
    push_item(mk_item(ACT_PUT, 8'h78, 11'd0));
    push_item(mk_item(ACT_PUT, 8'h79, 11'd0));
    push_item(mk_item(ACT_PUT, 8'h7A, 11'd0));
    push_item(mk_item(ACT_PUT, CHAR_NEWLINE, 11'd0));
    push_item(mk_item(ACT_PUT, 8'h70, 11'd0));
    push_item(mk_item(ACT_PUT, 8'h71, 11'd0));
    push_item(mk_item(ACT_PUT, 8'h72, 11'd0));
    push_item(mk_item(ACT_PUT, CHAR_BACKSPACE, 11'd0));
    push_item(mk_item(ACT_READ, 8'h00, 11'd0));
    push_item(mk_item(ACT_READ, 8'h00, 11'd5));
    push_item(mk_item(ACT_READ, 8'h00, 11'd6));
    in_valid_i <= 1'b0;
    settle();

    for (int phase = 0; phase < 11; phase++) begin
      case (phase)
        0:       begin cols = 2;   rws = 2;  color = 8'h00; count = 150; end
        1:       begin cols = 80;  rws = 25; color = 8'hFF; count = 200; end
        2:       begin cols = 5;   rws = 3;  color = 8'h1E; count = 200; end
        3:       begin cols = 0;   rws = 1;  color = 8'h5A; count = 100; end  // below range
        4:       begin cols = 127; rws = 31; color = 8'hA5; count = 150; end  // above range
        5:       begin cols = 80;  rws = 2;  color = 8'h0F; count = 150; end
        6:       begin cols = 2;   rws = 25; color = 8'hF0; count = 150; end
        default: begin
          cols = $urandom_range(2, 80);
          rws = $urandom_range(2, 25);
          color = $urandom_range(0, 255);
          count = 125;
        end
      endcase
      set_screen(cols, rws, color);
      repeat (count) begin
        pace();
        push_item(random_item());
      end
      in_valid_i <= 1'b0;
      settle();
    end

    repeat (50) @(posedge clk_i);
    $display("Drove %0d console transfers across %0d screen settings, 2x2 to 80x25 plus",
             items_sent, settings_used);
    $display("out-of-range register values; %0d results checked, %0d scrolls, %0d mismatches.",
             results, scrolls, mismatches);
    if (mismatches == 0) begin
      $display("text_console_cell_writer_top verification clean");
    end else begin
      $display("text_console_cell_writer_top verification failed");
    end
    $finish;
  end

endmodule

@@ text_console_cell_writer_top.f @@
src/tccw_pkg.sv
src/tccw_cell_ram.sv
src/tccw_ctrl.sv
src/text_console_cell_writer_top.sv
test/text_console_cell_writer_checker.sv
test/text_console_cell_writer_top_tb.sv
